@@ src/lzw_byte_compressor_macros.svh @@
// ----------------------------------------------------------------------------
// lzw byte compressor assertion macros
// Shared concurrent assertion forms, compiled out with NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef LZW_BYTE_COMPRESSOR_MACROS_SVH
`define LZW_BYTE_COMPRESSOR_MACROS_SVH

`ifndef NO_ASSERTIONS

`define LZW_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lzw same-cycle check failed");

`define LZW_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lzw next-cycle check failed");

`else

`define LZW_ASSERT_SAME(label, ante, cons)

`define LZW_ASSERT_NEXT(label, ante, cons)

`endif

`endif

@@ src/lzw_pkg.sv @@
// ----------------------------------------------------------------------------
// lzw package
// Widths, slot layout, sequencer states and shared types.
// ----------------------------------------------------------------------------
package lzw_pkg;

  localparam int CODE_BITS     = 12;
  localparam int HASH_BITS     = 13;
  localparam int HASH_SLOTS    = 2 ** HASH_BITS;
  localparam int KEY_BITS      = CODE_BITS + 8;
  localparam int NFC_BITS      = CODE_BITS + 1;
  localparam int PROBE_BITS    = HASH_BITS + 1;
  localparam int OUT_CODE_BITS = 12;
  localparam int EPOCH_BITS    = 4;
  localparam int FIRST_CODE    = 256;

  localparam logic [31:0]           HASH_MULT   = 32'h9E37_79B1;
  localparam logic [EPOCH_BITS-1:0] EPOCH_FIRST = EPOCH_BITS'(1);
  localparam logic [EPOCH_BITS-1:0] EPOCH_MAX   = '1;

  typedef logic [HASH_BITS-1:0] slot_addr_t;

  // a slot is live only when its epoch equals the current one
  typedef struct packed {
    logic [EPOCH_BITS-1:0] epoch;
    logic [KEY_BITS-1:0]   key;
    logic [CODE_BITS-1:0]  code;
  } slot_t;

  localparam int SLOT_BITS = $bits(slot_t);

  typedef struct packed {
    logic       we;
    slot_addr_t waddr;
    slot_t      wdata;
    logic       re;
    slot_addr_t raddr;
  } ram_req_t;

  typedef struct packed {
    logic                     valid;
    logic [OUT_CODE_BITS-1:0] code;
    logic                     last;
  } emit_t;

  typedef struct packed {
    logic idle;
    logic clearing;
    logic prefix_valid;
  } ctrl_status_t;

  typedef enum logic [6:0] {
    ST_CLEAR     = 7'b000_0001,
    ST_IDLE      = 7'b000_0010,
    ST_HASH      = 7'b000_0100,
    ST_ADDR      = 7'b000_1000,
    ST_CHECK     = 7'b001_0000,
    ST_EMIT_MISS = 7'b010_0000,
    ST_EMIT_LAST = 7'b100_0000
  } state_t;

  function automatic logic [OUT_CODE_BITS-1:0] to_out_code(input logic [CODE_BITS-1:0] c);
    logic [31:0] wide;
    wide = 32'(c);
    return wide[OUT_CODE_BITS-1:0];
  endfunction

endpackage

@@ src/lzw_ram.sv @@
// ----------------------------------------------------------------------------
// lzw generic ram
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module lzw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ src/lzw_hash.sv @@
// ----------------------------------------------------------------------------
// lzw hash unit
// Multiplicative hash of the (prefix, byte) key; product registered, then
// folded and masked down to a slot index.
// ----------------------------------------------------------------------------
module lzw_hash (
  input  logic                         clk,
  input  logic                         start,
  input  logic [lzw_pkg::KEY_BITS-1:0] key,
  output lzw_pkg::slot_addr_t          idx
);

  logic [31:0] prod_r;
  logic [31:0] prod_nxt;
  logic [31:0] folded;

  assign prod_nxt = 32'(32'(key) * lzw_pkg::HASH_MULT);

  always_ff @(posedge clk) begin
    if (start) begin
      prod_r <= prod_nxt;
    end
  end

  assign folded = prod_r ^ (prod_r >> 15);
  assign idx    = folded[lzw_pkg::HASH_BITS-1:0];

endmodule

@@ src/lzw_ctrl.sv @@
// ----------------------------------------------------------------------------
// lzw sequencer
// Takes bytes, drives the hash unit and the linear probe over the slot ram,
// inserts new pairs, hands codes to the output register and clears the ram.
// ----------------------------------------------------------------------------
module lzw_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic [7:0]                   in_data_byte,
  input  logic                         in_end_of_data,
  output logic                         in_stall,
  output logic [lzw_pkg::KEY_BITS-1:0] hash_key,
  output logic                         hash_start,
  input  lzw_pkg::slot_addr_t          hash_idx,
  output lzw_pkg::ram_req_t            ram_req,
  input  lzw_pkg::slot_t               ram_rdata,
  input  logic                         out_free,
  output lzw_pkg::emit_t               emit,
  output lzw_pkg::ctrl_status_t        status
);

  lzw_pkg::state_t state_r, state_nxt;

  logic [7:0]                        byte_r, byte_nxt;
  logic                              end_r, end_nxt;
  logic [lzw_pkg::CODE_BITS-1:0]     prefix_r, prefix_nxt;
  logic                              prefix_valid_r, prefix_valid_nxt;
  logic [lzw_pkg::NFC_BITS-1:0]      next_free_r, next_free_nxt;
  logic [lzw_pkg::EPOCH_BITS-1:0]    epoch_r, epoch_nxt;
  lzw_pkg::slot_addr_t               idx_r, idx_nxt;
  logic [lzw_pkg::PROBE_BITS-1:0]    probe_cnt_r, probe_cnt_nxt;
  lzw_pkg::slot_addr_t               clr_cnt_r, clr_cnt_nxt;
  logic                              free_ok_r, free_ok_nxt;

  logic in_accept;
  logic slot_live;
  logic key_match;

  assign hash_key  = {prefix_r, byte_r};
  assign in_stall  = (state_r != lzw_pkg::ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign slot_live = (ram_rdata.epoch == epoch_r);
  assign key_match = (ram_rdata.key == hash_key);

  always_comb begin
    state_nxt        = state_r;
    byte_nxt         = byte_r;
    end_nxt          = end_r;
    prefix_nxt       = prefix_r;
    prefix_valid_nxt = prefix_valid_r;
    next_free_nxt    = next_free_r;
    epoch_nxt        = epoch_r;
    idx_nxt          = idx_r;
    probe_cnt_nxt    = probe_cnt_r;
    clr_cnt_nxt      = clr_cnt_r;
    free_ok_nxt      = free_ok_r;
    hash_start       = 1'b0;
    ram_req          = '0;
    emit             = '0;

    unique case (state_r)
      lzw_pkg::ST_CLEAR: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = clr_cnt_r;
        ram_req.wdata = '0;
        clr_cnt_nxt   = clr_cnt_r + 1'b1;
        if (clr_cnt_r == '1) begin
          epoch_nxt = lzw_pkg::EPOCH_FIRST;
          state_nxt = lzw_pkg::ST_IDLE;
        end
      end
      lzw_pkg::ST_IDLE: begin
        if (in_accept) begin
          byte_nxt = in_data_byte;
          end_nxt  = in_end_of_data;
          if (!prefix_valid_r) begin
            // first byte of a stream just becomes the prefix
            prefix_nxt       = lzw_pkg::CODE_BITS'(in_data_byte);
            prefix_valid_nxt = 1'b1;
            state_nxt        = in_end_of_data ? lzw_pkg::ST_EMIT_LAST : lzw_pkg::ST_IDLE;
          end else begin
            state_nxt = lzw_pkg::ST_HASH;
          end
        end
      end
      lzw_pkg::ST_HASH: begin
        hash_start = 1'b1;
        state_nxt  = lzw_pkg::ST_ADDR;
      end
      lzw_pkg::ST_ADDR: begin
        ram_req.re    = 1'b1;
        ram_req.raddr = hash_idx;
        idx_nxt       = hash_idx;
        probe_cnt_nxt = lzw_pkg::PROBE_BITS'(1);
        state_nxt     = lzw_pkg::ST_CHECK;
      end
      lzw_pkg::ST_CHECK: begin
        if (!slot_live) begin
          free_ok_nxt = 1'b1;
          state_nxt   = lzw_pkg::ST_EMIT_MISS;
        end else if (key_match) begin
          prefix_nxt = ram_rdata.code;
          state_nxt  = end_r ? lzw_pkg::ST_EMIT_LAST : lzw_pkg::ST_IDLE;
        end else if (probe_cnt_r == lzw_pkg::PROBE_BITS'(lzw_pkg::HASH_SLOTS)) begin
          // every slot probed and taken: pair cannot be added
          free_ok_nxt = 1'b0;
          state_nxt   = lzw_pkg::ST_EMIT_MISS;
        end else begin
          idx_nxt       = idx_r + 1'b1;
          probe_cnt_nxt = probe_cnt_r + 1'b1;
          ram_req.re    = 1'b1;
          ram_req.raddr = idx_r + 1'b1;
        end
      end
      lzw_pkg::ST_EMIT_MISS: begin
        if (out_free) begin
          emit.valid = 1'b1;
          emit.code  = lzw_pkg::to_out_code(prefix_r);
          emit.last  = 1'b0;
          if (free_ok_r && !next_free_r[lzw_pkg::CODE_BITS]) begin
            ram_req.we          = 1'b1;
            ram_req.waddr       = idx_r;
            ram_req.wdata.epoch = epoch_r;
            ram_req.wdata.key   = hash_key;
            ram_req.wdata.code  = next_free_r[lzw_pkg::CODE_BITS-1:0];
            next_free_nxt       = next_free_r + 1'b1;
          end
          prefix_nxt = lzw_pkg::CODE_BITS'(byte_r);
          state_nxt  = end_r ? lzw_pkg::ST_EMIT_LAST : lzw_pkg::ST_IDLE;
        end
      end
      lzw_pkg::ST_EMIT_LAST: begin
        if (out_free) begin
          emit.valid       = 1'b1;
          emit.code        = lzw_pkg::to_out_code(prefix_r);
          emit.last        = 1'b1;
          prefix_nxt       = '0;
          prefix_valid_nxt = 1'b0;
          next_free_nxt    = lzw_pkg::NFC_BITS'(lzw_pkg::FIRST_CODE);
          // new epoch drops the whole dictionary; wipe the ram when epochs run out
          if (epoch_r == lzw_pkg::EPOCH_MAX) begin
            clr_cnt_nxt = '0;
            state_nxt   = lzw_pkg::ST_CLEAR;
          end else begin
            epoch_nxt = epoch_r + 1'b1;
            state_nxt = lzw_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = lzw_pkg::ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= lzw_pkg::ST_CLEAR;
      prefix_r       <= '0;
      prefix_valid_r <= 1'b0;
      next_free_r    <= lzw_pkg::NFC_BITS'(lzw_pkg::FIRST_CODE);
      epoch_r        <= lzw_pkg::EPOCH_FIRST;
      clr_cnt_r      <= '0;
      probe_cnt_r    <= '0;
      free_ok_r      <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      prefix_r       <= prefix_nxt;
      prefix_valid_r <= prefix_valid_nxt;
      next_free_r    <= next_free_nxt;
      epoch_r        <= epoch_nxt;
      clr_cnt_r      <= clr_cnt_nxt;
      probe_cnt_r    <= probe_cnt_nxt;
      free_ok_r      <= free_ok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    end_r  <= end_nxt;
    idx_r  <= idx_nxt;
  end

  assign status.idle         = (state_r == lzw_pkg::ST_IDLE);
  assign status.clearing     = (state_r == lzw_pkg::ST_CLEAR);
  assign status.prefix_valid = prefix_valid_r;

endmodule

@@ src/lzw_byte_compressor.sv @@
// ----------------------------------------------------------------------------
// lzw byte compressor: 12-bit code lzw over a hashed 8192-slot dictionary ram
// A stream's first byte becomes the prefix (and is emitted if it ends the
// stream); each later byte passes the hash and address states, one check per
// slot probed, and an emit state per code (two on a final miss) that waits out
// any output stall. A code shows on out_valid the cycle after its emit state.
// Sync reset runs a clearing pass over all 8192 ram slots, repeated after
// every 15th stream, while the input is stalled.
// ----------------------------------------------------------------------------
`include "lzw_byte_compressor_macros.svh"

module lzw_byte_compressor (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [7:0]                          in_data_byte,
  input  logic                                in_end_of_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [lzw_pkg::OUT_CODE_BITS-1:0]   out_code,
  output logic                                out_last
);

  logic [lzw_pkg::KEY_BITS-1:0] hash_key;
  logic                         hash_start;
  lzw_pkg::slot_addr_t          hash_idx;
  lzw_pkg::ram_req_t            ram_req;
  lzw_pkg::slot_t               ram_rdata;
  lzw_pkg::emit_t               emit;
  lzw_pkg::ctrl_status_t        status;
  logic                         out_free;

  logic                              out_valid_r;
  logic [lzw_pkg::OUT_CODE_BITS-1:0] out_code_r;
  logic                              out_last_r;

  lzw_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_data_byte   (in_data_byte),
    .in_end_of_data (in_end_of_data),
    .in_stall       (in_stall),
    .hash_key       (hash_key),
    .hash_start     (hash_start),
    .hash_idx       (hash_idx),
    .ram_req        (ram_req),
    .ram_rdata      (ram_rdata),
    .out_free       (out_free),
    .emit           (emit),
    .status         (status)
  );

  lzw_hash u_hash (
    .clk   (clk),
    .start (hash_start),
    .key   (hash_key),
    .idx   (hash_idx)
  );

  lzw_ram #(
    .WIDTH (lzw_pkg::SLOT_BITS),
    .DEPTH (lzw_pkg::HASH_SLOTS)
  ) u_dict_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

  // output register frees up in the same cycle its beat is taken
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit.valid) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.valid) begin
      out_code_r <= emit.code;
      out_last_r <= emit.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_code  = out_code_r;
  assign out_last  = out_last_r;

  `LZW_ASSERT_SAME(a_emit_has_room, emit.valid, !out_valid_r || !out_stall)
  `LZW_ASSERT_SAME(a_miss_needs_prefix, emit.valid && !emit.last, status.prefix_valid)
  `LZW_ASSERT_NEXT(a_last_ends_stream, emit.valid && emit.last, !status.prefix_valid)
  `LZW_ASSERT_SAME(a_busy_stalls, !status.idle, in_stall)
  `LZW_ASSERT_SAME(a_clear_silent, status.clearing, !emit.valid)

endmodule
